FILE: sv/bmpd_pkg.sv
// shared types and codes for the bmp pixel stream decoder
package bmpd_pkg;

    // pixel format codes of the mode register
    typedef enum logic [1:0] {
        MODE_IDX4  = 2'd0,
        MODE_IDX8  = 2'd1,
        MODE_BGR24 = 2'd2,
        MODE_BGRA32 = 2'd3
    } bpp_mode_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MODE   = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } cfg_reg_t;

    localparam int CFG_DATA_W = 13;
    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;

    // colour table sizes in bytes
    localparam logic [10:0] TABLE_BYTES_IDX4 = 11'd64;
    localparam logic [10:0] TABLE_BYTES_IDX8 = 11'd1024;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_body;
    } byte_word_t;

    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [7:0]       alpha;
        logic [POS_W-1:0] pixel_column;
        logic [POS_W-1:0] pixel_row;
        logic             last_pixel;
        logic             alpha_all_zero;
    } pixel_word_t;

endpackage

FILE: sv/bmp_pixel_stream_decoder.sv
// top level of the bmp pixel stream decoder: byte parsing, palette and pixel output
//
// channel   | direction | handshake                  | word
// ----------+-----------+----------------------------+----------------------------------
// byte      | in        | byte_valid / byte_stall    | data_byte, start_of_body
// pixel     | out       | pixel_valid / pixel_stall  | rgba, column, row, last, all-zero
// cfg       | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one byte per cycle when not stalled; counters and palette writes settle on accept
// accepted byte and palette read are registered, then formatted into the output register
// 4-bit indexed bytes give up to two pixels; the single output port sends them in turn
// reset (async, active low) clears counters and pipeline valids; the palette is not cleared
// a stall on the pixel side holds the output register and backs up to byte_stall
module bmp_pixel_stream_decoder #(
    parameter int MAX_WIDTH     = 4096,
    parameter int MAX_HEIGHT    = 4096,
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                byte_valid,
    output logic                                byte_stall,
    input  bmpd_pkg::byte_word_t                byte_word,
    output logic                                pixel_valid,
    input  logic                                pixel_stall,
    output bmpd_pkg::pixel_word_t               pixel_word,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_index,
    input  logic [bmpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    // clamp limits folded to the register width
    localparam int WCAP  = (MAX_WIDTH  > 8191) ? 8191 : MAX_WIDTH;
    localparam int HCAP  = (MAX_HEIGHT > 8191) ? 8191 : MAX_HEIGHT;
    localparam logic [bmpd_pkg::DIM_W-1:0] WCAP_V = bmpd_pkg::DIM_W'(WCAP);
    localparam logic [bmpd_pkg::DIM_W-1:0] HCAP_V = bmpd_pkg::DIM_W'(HCAP);

    // one pending pixel between the parse stage and the output register
    typedef struct packed {
        logic                         indexed;
        logic                         oob;
        logic [31:0]                  rgba;
        logic [bmpd_pkg::POS_W-1:0]   col;
        logic [bmpd_pkg::POS_W-1:0]   row;
        logic                         last;
        logic                         aaz;
    } slot_t;

    // configuration registers
    bmpd_pkg::bpp_mode_t            mode_reg;
    logic [bmpd_pkg::DIM_W-1:0]     width_reg;
    logic [bmpd_pkg::DIM_W-1:0]     height_reg;

    // parse state
    logic [9:0]                     tbc_reg, tbc_next;
    logic                           phase_reg, phase_next;
    logic [bmpd_pkg::DIM_W-1:0]     col_reg, col_next;
    logic [bmpd_pkg::DIM_W-1:0]     row_reg, row_next;
    logic [1:0]                     bip_reg, bip_next;
    logic [23:0]                    part_reg, part_next;
    logic [1:0]                     pad_reg, pad_next;
    logic                           nza_reg, nza_next;

    // palette
    logic [31:0]                    pal_mem [PALETTE_DEPTH];
    logic                           pal_we;
    logic [IDX_W-1:0]               pal_waddr;
    logic [1:0]                     pal_lane;
    logic [IDX_W-1:0]               rd_addr0, rd_addr1;
    logic [31:0]                    rd0_reg, rd1_reg;

    // pending slots and output register
    slot_t                          slot0_reg, slot1_reg;
    slot_t                          slot0_new, slot1_new;
    logic                           s0_v, s1_v;
    logic [1:0]                     bval_reg, bval_next;
    logic                           out_valid_reg, out_valid_next;
    bmpd_pkg::pixel_word_t          out_word_reg, out_word_next;

    logic                           accept;
    logic                           out_free;
    logic                           move;
    logic                           head;

    logic [bmpd_pkg::DIM_W-1:0]     eff_w, eff_h;

    assign cfg_ready = 1'b1;

    // width and height clamped to 1..max
    always_comb
    begin
        if (width_reg == '0)
            eff_w = bmpd_pkg::DIM_W'(1);
        else if (width_reg > WCAP_V)
            eff_w = WCAP_V;
        else
            eff_w = width_reg;
        if (height_reg == '0)
            eff_h = bmpd_pkg::DIM_W'(1);
        else if (height_reg > HCAP_V)
            eff_h = HCAP_V;
        else
            eff_h = height_reg;
    end

    // handshakes: a new byte enters only when the pending slots will be empty
    assign out_free   = !out_valid_reg || !pixel_stall;
    assign move       = (bval_reg != 2'b00) && out_free;
    assign head       = !bval_reg[0];
    assign byte_stall = !((bval_reg == 2'b00) ||
                          (move && (bval_reg != 2'b11)));
    assign accept     = byte_valid && !byte_stall;

    // parse stage: counters, palette write address, pixel slots
    always_comb
    begin
        logic [7:0]                   byt;
        logic                         proceed;
        logic [10:0]                  tbc_inc;
        logic [10:0]                  table_end;
        logic [7:0]                   entry;
        logic [7:0]                   idx0, idx1;
        logic [bmpd_pkg::DIM_W:0]     col_a, col_b, row_a;
        logic                         wrap_a, wrap_b;
        logic [bmpd_pkg::DIM_W-1:0]   c1, r1, h_m1;
        logic [bmpd_pkg::DIM_W:0]     w_p1;
        logic [3:0]                   w3;
        logic [1:0]                   rb2;
        logic [1:0]                   pad_row;
        logic [2:0]                   bip_p1;
        logic [2:0]                   need;
        logic [7:0]                   pr, pg, pb, pa;
        logic                         any_wrap;

        byt       = byte_word.data_byte;
        proceed   = 1'b0;
        tbc_inc   = '0;
        table_end = bmpd_pkg::TABLE_BYTES_IDX8;
        entry     = '0;
        idx0      = '0;
        idx1      = '0;
        col_a     = '0;
        col_b     = '0;
        row_a     = '0;
        wrap_a    = 1'b0;
        wrap_b    = 1'b0;
        c1        = '0;
        r1        = '0;
        w_p1      = '0;
        w3        = '0;
        rb2       = '0;
        pad_row   = '0;
        bip_p1    = '0;
        need      = 3'd4;
        pr        = '0;
        pg        = '0;
        pb        = '0;
        pa        = '0;
        any_wrap  = 1'b0;

        // start of body clears every counter before the byte is used
        if (byte_word.start_of_body)
        begin
            tbc_next   = '0;
            phase_next = 1'b0;
            col_next   = '0;
            row_next   = '0;
            bip_next   = '0;
            part_next  = '0;
            pad_next   = '0;
            nza_next   = 1'b0;
        end
        else
        begin
            tbc_next   = tbc_reg;
            phase_next = phase_reg;
            col_next   = col_reg;
            row_next   = row_reg;
            bip_next   = bip_reg;
            part_next  = part_reg;
            pad_next   = pad_reg;
            nza_next   = nza_reg;
        end

        pal_we    = 1'b0;
        entry     = tbc_next[9:2];
        pal_waddr = entry[IDX_W-1:0];
        pal_lane  = tbc_next[1:0];
        s0_v      = 1'b0;
        s1_v      = 1'b0;
        slot0_new = '0;
        slot1_new = '0;

        h_m1 = eff_h - bmpd_pkg::DIM_W'(1);

        // padding owed at the end of a stored row
        w_p1 = {1'b0, eff_w} + 1'b1;
        w3   = {2'b00, eff_w[1:0]} * 4'd3;
        case (mode_reg)
            bmpd_pkg::MODE_IDX4:  rb2 = w_p1[2:1];
            bmpd_pkg::MODE_IDX8:  rb2 = eff_w[1:0];
            bmpd_pkg::MODE_BGR24: rb2 = w3[1:0];
            default:              rb2 = 2'b00;
        endcase
        pad_row = 2'b00 - rb2;

        if (!phase_next)
        begin
            if (mode_reg == bmpd_pkg::MODE_BGR24 || mode_reg == bmpd_pkg::MODE_BGRA32)
            begin
                phase_next = 1'b1;
                proceed    = 1'b1;
            end
            else
            begin
                // colour table byte
                table_end = (mode_reg == bmpd_pkg::MODE_IDX4) ?
                            bmpd_pkg::TABLE_BYTES_IDX4 : bmpd_pkg::TABLE_BYTES_IDX8;
                pal_we    = ({24'd0, entry} < PALETTE_DEPTH);
                tbc_inc   = {1'b0, tbc_next} + 11'd1;
                tbc_next  = tbc_inc[9:0];
                if ({1'b0, tbc_next} >= table_end || tbc_next == '0)
                    phase_next = 1'b1;
            end
        end
        else
        begin
            proceed = 1'b1;
        end

        // first pixel position and advance
        col_a  = {1'b0, col_next} + 1'b1;
        wrap_a = (col_a >= {1'b0, eff_w});
        row_a  = {1'b0, row_next} + 1'b1;
        c1     = wrap_a ? '0 : col_a[bmpd_pkg::DIM_W-1:0];
        r1     = wrap_a ? row_a[bmpd_pkg::DIM_W-1:0] : row_next;
        // second nibble sits on the same row, so only the column moves
        col_b  = {1'b0, c1} + 1'b1;
        wrap_b = (col_b >= {1'b0, eff_w});

        slot0_new.col  = col_next[bmpd_pkg::POS_W-1:0];
        slot0_new.row  = 12'(h_m1 - row_next);
        slot0_new.last = wrap_a && (row_a >= {1'b0, eff_h});
        slot1_new.col  = c1[bmpd_pkg::POS_W-1:0];
        slot1_new.row  = 12'(h_m1 - r1);
        slot1_new.last = wrap_b && (row_a >= {1'b0, eff_h});

        idx0 = (mode_reg == bmpd_pkg::MODE_IDX4) ? {4'd0, byt[7:4]} : byt;
        idx1 = {4'd0, byt[3:0]};
        slot0_new.indexed = 1'b1;
        slot0_new.oob     = ({24'd0, idx0} >= PALETTE_DEPTH);
        slot1_new.indexed = 1'b1;
        slot1_new.oob     = ({24'd0, idx1} >= PALETTE_DEPTH);

        bip_p1 = {1'b0, bip_next} + 3'd1;

        if (proceed && (row_next < eff_h))
        begin
            if (pad_next != 2'b00)
            begin
                pad_next = pad_next - 2'd1;
            end
            else
            begin
                case (mode_reg)
                    bmpd_pkg::MODE_IDX4:
                    begin
                        s0_v = 1'b1;
                        s1_v = (c1 != '0);
                    end
                    bmpd_pkg::MODE_IDX8:
                    begin
                        s0_v = 1'b1;
                    end
                    default:
                    begin
                        need = (mode_reg == bmpd_pkg::MODE_BGR24) ? 3'd3 : 3'd4;
                        if (bip_p1 >= need)
                        begin
                            pb = part_next[7:0];
                            pg = part_next[15:8];
                            pr = part_next[23:16];
                            pa = bmpd_pkg::ALPHA_OPAQUE;
                            if (mode_reg == bmpd_pkg::MODE_BGR24)
                                pr = byt;
                            else
                                pa = byt;
                            bip_next  = '0;
                            part_next = '0;
                            s0_v      = 1'b1;
                            slot0_new.indexed = 1'b0;
                            slot0_new.oob     = 1'b0;
                            slot0_new.rgba    = {pr, pg, pb, pa};
                            if (mode_reg == bmpd_pkg::MODE_BGRA32)
                            begin
                                if (pa != 8'd0)
                                    nza_next = 1'b1;
                                slot0_new.aaz = slot0_new.last && !nza_next;
                            end
                        end
                        else
                        begin
                            case (bip_next)
                                2'd0:    part_next[7:0]   = byt;
                                2'd1:    part_next[15:8]  = byt;
                                2'd2:    part_next[23:16] = byt;
                                default: part_next        = part_next;
                            endcase
                            bip_next = bip_p1[1:0];
                        end
                    end
                endcase
            end
        end

        // counters advance for each pixel put out
        if (s0_v)
        begin
            col_next = c1;
            row_next = r1;
            any_wrap = wrap_a;
            if (s1_v)
            begin
                col_next = wrap_b ? '0 : col_b[bmpd_pkg::DIM_W-1:0];
                row_next = wrap_b ? row_a[bmpd_pkg::DIM_W-1:0] : r1;
                any_wrap = wrap_b;
            end
        end
        if (any_wrap)
        begin
            bip_next = '0;
            pad_next = pad_row;
        end

        rd_addr0 = idx0[IDX_W-1:0];
        rd_addr1 = idx1[IDX_W-1:0];
    end

    // palette store: byte-wide writes from the colour table, two registered reads
    always_ff @(posedge clk)
    begin
        if (accept && pal_we)
            pal_mem[pal_waddr][pal_lane*8 +: 8] <= byte_word.data_byte;
        if (accept)
        begin
            rd0_reg <= pal_mem[rd_addr0];
            rd1_reg <= pal_mem[rd_addr1];
        end
    end

    // format the head slot for the output register
    always_comb
    begin
        slot_t       s;
        logic [31:0] e;

        s = head ? slot1_reg : slot0_reg;
        e = head ? rd1_reg : rd0_reg;

        bval_next = bval_reg;
        if (move)
            bval_next[head] = 1'b0;
        if (accept)
            bval_next = {s1_v, s0_v};

        out_word_next.pixel_column   = s.col;
        out_word_next.pixel_row      = s.row;
        out_word_next.last_pixel     = s.last;
        out_word_next.alpha_all_zero = s.aaz;
        if (!s.indexed)
        begin
            {out_word_next.red, out_word_next.green,
             out_word_next.blue, out_word_next.alpha} = s.rgba;
        end
        else if (s.oob)
        begin
            out_word_next.red   = '0;
            out_word_next.green = '0;
            out_word_next.blue  = '0;
            out_word_next.alpha = '0;
        end
        else
        begin
            // palette entry byte order is b, g, r, a from the low end
            out_word_next.red   = e[23:16];
            out_word_next.green = e[15:8];
            out_word_next.blue  = e[7:0];
            out_word_next.alpha = (e[31:24] == 8'd0) ? bmpd_pkg::ALPHA_OPAQUE : e[31:24];
        end

        out_valid_next = out_free ? move : out_valid_reg;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= bmpd_pkg::MODE_IDX8;
            width_reg     <= bmpd_pkg::DIM_W'(1);
            height_reg    <= bmpd_pkg::DIM_W'(1);
            tbc_reg       <= '0;
            phase_reg     <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            bip_reg       <= '0;
            part_reg      <= '0;
            pad_reg       <= '0;
            nza_reg       <= 1'b0;
            bval_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    bmpd_pkg::REG_MODE:   mode_reg   <= bmpd_pkg::bpp_mode_t'(cfg_data[1:0]);
                    bmpd_pkg::REG_WIDTH:  width_reg  <= cfg_data;
                    bmpd_pkg::REG_HEIGHT: height_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (accept)
            begin
                tbc_reg   <= tbc_next;
                phase_reg <= phase_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                bip_reg   <= bip_next;
                part_reg  <= part_next;
                pad_reg   <= pad_next;
                nza_reg   <= nza_next;
            end
            bval_reg      <= bval_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot0_reg <= slot0_new;
            slot1_reg <= slot1_new;
        end
        if (out_free && move)
            out_word_reg <= out_word_next;
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_word  = out_word_reg;

endmodule

FILE: sv/bmpd_checker.sv
// port-level checks for the bmp pixel stream decoder and their bind
module bmpd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input bmpd_pkg::pixel_word_t pixel_word
);

    // a stalled word stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid)
        else $error("pixel word dropped while stalled");

    // the all-zero alpha flag only comes with the final pixel
    a_flag_last: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_word.alpha_all_zero |-> pixel_word.last_pixel)
        else $error("alpha_all_zero without last_pixel");

    // the flag means every alpha was zero, this pixel included
    a_flag_alpha: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_word.alpha_all_zero |-> pixel_word.alpha == 8'd0)
        else $error("alpha_all_zero on a pixel with nonzero alpha");

    // a flagged pixel ends the image, so the row is the top one
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_word.last_pixel |-> pixel_word.pixel_row == 12'd0)
        else $error("last pixel not on output row zero");

endmodule

bind bmp_pixel_stream_decoder bmpd_checker u_bmpd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel_word  (pixel_word)
);
